### rtl/dnt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Directional neighbor table package
// Shared action codes, direction codes and field widths.
// ----------------------------------------------------------------------------
package dnt_pkg;

    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned ID_W    = 32;
    localparam int unsigned ROAD_W  = 16;
    localparam int unsigned POS_W   = 24;
    localparam int unsigned DIR_W   = 4;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned COUNT_W = 7;

    typedef enum logic [1:0] {
        ACT_UPDATE = 2'd0,
        ACT_LOOKUP = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    localparam logic [DIR_W-1:0] DIR_ANY     = 4'hF;
    localparam logic [DIR_W-1:0] DIR_X_GREAT = 4'd1;
    localparam logic [DIR_W-1:0] DIR_Y_SMALL = 4'd2;
    localparam logic [DIR_W-1:0] DIR_X_SMALL = 4'd3;
    localparam logic [DIR_W-1:0] DIR_Y_GREAT = 4'd4;

endpackage
`default_nettype wire

### rtl/dnt_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Directional neighbor table channels
// Input item, result item and configuration write channels.
// ----------------------------------------------------------------------------
interface dnt_in_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   action;
    logic [dnt_pkg::ADDR_W-1:0]   node_addr;
    logic [dnt_pkg::ID_W-1:0]     node_id;
    logic [dnt_pkg::ROAD_W-1:0]   road_id;
    logic [dnt_pkg::POS_W-1:0]    pos_x;
    logic [dnt_pkg::POS_W-1:0]    pos_y;
    logic signed [dnt_pkg::DIR_W-1:0] direction;
    logic [dnt_pkg::TIME_W-1:0]   now_time;
    modport source (output valid, action, node_addr, node_id, road_id, pos_x, pos_y,
                    direction, now_time, input ready);
    modport sink (input valid, action, node_addr, node_id, road_id, pos_x, pos_y,
                  direction, now_time, output ready);
endinterface

interface dnt_out_if;
    logic                        valid;
    logic                        ready;
    logic [dnt_pkg::ADDR_W-1:0]  next_hop_addr;
    logic                        found;
    logic                        dropped;
    logic [dnt_pkg::COUNT_W-1:0] entry_count;
    modport source (output valid, next_hop_addr, found, dropped, entry_count,
                    input ready);
    modport sink (input valid, next_hop_addr, found, dropped, entry_count,
                  output ready);
endinterface

interface dnt_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [dnt_pkg::TIME_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

### rtl/dnt_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Directional neighbor table entry memory
// Single write port, single registered read port.
// ----------------------------------------------------------------------------
module dnt_mem #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned WIDTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### rtl/directional_neighbor_table_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Directional neighbor table core
// Compacted neighbor table with purge, refresh/append and nearest lookup.
// ----------------------------------------------------------------------------
// An update purges aged entries, scans the rest for a match and then writes;
// a lookup scans every entry for the nearest one; an empty table skips the
// scans, and clear and unused actions go straight to the result. One item is
// worked on at a time; the next is taken in the cycle after the result is accepted.
// The rate is set by the entry memory, scanned one entry per cycle.
// Reset empties the table at once and loads the expiry age (r_expire) with 1000.
module directional_neighbor_table_core #(
    parameter int unsigned TABLE_ENTRIES = 64,
    parameter int unsigned COORD_BITS    = 24,
    parameter int unsigned ROAD_BITS     = 16
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    dnt_cfg_if.sink      cfg,
    dnt_in_if.sink       in_ch,
    dnt_out_if.source    out_ch
);
    import dnt_pkg::*;

    localparam int unsigned RD_W  = (ROAD_BITS < ROAD_W) ? ROAD_BITS : ROAD_W;
    localparam int unsigned CO_W  = (COORD_BITS < POS_W) ? COORD_BITS : POS_W;
    localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
    localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int unsigned D_W   = 2 * CO_W + 1;
    localparam int unsigned ENT_W = ADDR_W + ID_W + RD_W + 2 * CO_W + TIME_W;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_PREAD = 7'b0000010,
        ST_PURGE = 7'b0000100,
        ST_MATCH = 7'b0001000,
        ST_WRITE = 7'b0010000,
        ST_LOOK  = 7'b0100000,
        ST_OUT   = 7'b1000000
    } t_state;

    typedef struct packed {
        logic [ADDR_W-1:0]     addr;
        logic [ID_W-1:0]       id;
        logic [RD_W-1:0]       road;
        logic [CO_W-1:0]       x;
        logic [CO_W-1:0]       y;
        logic [TIME_W-1:0]     stamp;
    } t_entry;

    t_state r_state, n_state;
    logic [TIME_W-1:0] r_expire;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_ridx, n_ridx;
    logic [CNT_W-1:0]  r_widx, n_widx;
    logic              r_rvld, n_rvld;
    logic [IDX_W-1:0]  r_hit_idx, n_hit_idx;
    logic              r_hit, n_hit;

    t_action              r_act;
    logic [ADDR_W-1:0]    r_addr;
    logic [ID_W-1:0]      r_id;
    logic [RD_W-1:0]      r_road;
    logic [CO_W-1:0]      r_px, r_py;
    logic [DIR_W-1:0]     r_dir;
    logic [TIME_W-1:0]    r_now;

    logic              r_ovalid;
    logic [ADDR_W-1:0] r_ohop, n_ohop;
    logic              r_ofound, n_ofound;
    logic              r_odrop, n_odrop;

    logic [D_W-1:0]    r_best, n_best;
    logic [D_W-1:0]    r_dx2, r_dy2;
    logic              r_ok2;
    logic [ADDR_W-1:0] r_addr2;
    logic              r_v2;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr, mem_raddr;
    t_entry           mem_wdata, rd;
    logic [ENT_W-1:0] mem_rdata;

    dnt_mem #(.DEPTH(TABLE_ENTRIES), .WIDTH(ENT_W)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );
    assign rd = t_entry'(mem_rdata);

    assign cfg.ready   = i_rst_n;
    assign in_ch.ready = i_rst_n && (r_state == ST_IDLE) && !r_ovalid;
    assign out_ch.valid         = r_ovalid;
    assign out_ch.next_hop_addr = r_ohop;
    assign out_ch.found         = r_ofound;
    assign out_ch.dropped       = r_odrop;
    assign out_ch.entry_count   = COUNT_W'(r_count);

    logic [TIME_W-1:0]     age;
    logic                  keep;
    logic                  dir_ok;
    logic                  ent_ok;
    logic [CO_W-1:0]       ax, ay;
    logic [D_W-1:0]        dsum;

    assign mem_raddr = r_ridx[IDX_W-1:0];
    assign age  = r_now - rd.stamp;
    assign keep = !(age > r_expire);

    always_comb begin
        case (r_dir)
            DIR_ANY:     dir_ok = 1'b1;
            DIR_X_GREAT: dir_ok = r_px < rd.x;
            DIR_Y_SMALL: dir_ok = r_py > rd.y;
            DIR_X_SMALL: dir_ok = r_px > rd.x;
            DIR_Y_GREAT: dir_ok = r_py < rd.y;
            default:     dir_ok = 1'b0;
        endcase
    end
    assign ent_ok = dir_ok && (rd.id == r_id) && (rd.road == r_road);
    assign ax = (r_px > rd.x) ? r_px - rd.x : rd.x - r_px;
    assign ay = (r_py > rd.y) ? r_py - rd.y : rd.y - r_py;
    assign dsum = r_dx2 + r_dy2;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ridx    = r_ridx;
        n_widx    = r_widx;
        n_rvld    = 1'b0;
        n_hit     = r_hit;
        n_hit_idx = r_hit_idx;
        n_ohop    = r_ohop;
        n_ofound  = r_ofound;
        n_odrop   = r_odrop;
        n_best    = r_best;
        mem_we    = 1'b0;
        mem_waddr = r_widx[IDX_W-1:0];
        mem_wdata = rd;
        case (r_state)
            ST_IDLE: begin
                if (in_ch.valid && in_ch.ready) begin
                    n_ridx   = '0;
                    n_widx   = '0;
                    n_hit    = 1'b0;
                    n_ohop   = '0;
                    n_ofound = 1'b0;
                    n_odrop  = 1'b0;
                    case (t_action'(in_ch.action))
                        ACT_UPDATE: n_state = ST_PREAD;
                        ACT_LOOKUP: n_state = ST_PREAD;
                        ACT_CLEAR: begin
                            n_count = '0;
                            n_state = ST_OUT;
                        end
                        default: n_state = ST_OUT;
                    endcase
                end
            end
            ST_PREAD: begin
                if (r_count == '0) begin
                    n_state = (r_act == ACT_UPDATE) ? ST_WRITE : ST_OUT;
                end else begin
                    n_rvld  = 1'b1;
                    n_ridx  = r_ridx + 1'b1;
                    n_state = (r_act == ACT_UPDATE) ? ST_PURGE : ST_LOOK;
                end
            end
            ST_PURGE: begin
                // Read index runs one ahead of the data now on the port.
                if (keep) begin
                    mem_we = 1'b1;
                    n_widx = r_widx + 1'b1;
                end
                if (r_ridx == r_count) begin
                    n_count = keep ? r_widx + 1'b1 : r_widx;
                    n_ridx  = '0;
                    n_state = ST_MATCH;
                end else begin
                    n_ridx = r_ridx + 1'b1;
                end
            end
            ST_MATCH: begin
                if (r_rvld && !r_hit && rd.addr == r_addr && rd.id == r_id) begin
                    n_hit     = 1'b1;
                    n_hit_idx = IDX_W'(r_ridx - 1'b1);
                end
                if (r_ridx == r_count) begin
                    if (!r_rvld && r_count != '0) begin
                        n_state = ST_MATCH;
                        n_rvld  = 1'b0;
                    end else begin
                        n_state = ST_WRITE;
                    end
                end
                if (r_ridx != r_count) begin
                    n_rvld = 1'b1;
                    n_ridx = r_ridx + 1'b1;
                end
                if (r_ridx == r_count && r_count != '0 && !r_rvld && r_ridx == '0) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                mem_wdata.addr  = r_addr;
                mem_wdata.id    = r_id;
                mem_wdata.road  = r_road;
                mem_wdata.x     = r_px;
                mem_wdata.y     = r_py;
                mem_wdata.stamp = r_now;
                if (r_hit) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_hit_idx;
                end else if (r_count < CNT_W'(TABLE_ENTRIES)) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_count[IDX_W-1:0];
                    n_count   = r_count + 1'b1;
                end else begin
                    n_odrop = 1'b1;
                end
                n_state = ST_OUT;
            end
            ST_LOOK: begin
                if (r_ridx != r_count) begin
                    n_rvld = 1'b1;
                    n_ridx = r_ridx + 1'b1;
                end
                if (r_v2 && r_ok2 && (!r_ofound || dsum < r_best)) begin
                    n_best   = dsum;
                    n_ohop   = r_addr2;
                    n_ofound = 1'b1;
                end
                if (!r_rvld && !n_rvld && !r_v2) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_expire <= TIME_W'(1000);
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_rvld   <= 1'b0;
            r_v2     <= 1'b0;
            r_hit    <= 1'b0;
            r_ridx   <= '0;
            r_widx   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_rvld  <= n_rvld;
            r_hit   <= n_hit;
            r_ridx  <= n_ridx;
            r_widx  <= n_widx;
            r_v2    <= (r_state == ST_LOOK) && r_rvld;
            if (cfg.valid) begin
                r_expire <= cfg.data;
            end
            if (r_state == ST_OUT) begin
                r_ovalid <= 1'b1;
            end else if (out_ch.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit_idx <= n_hit_idx;
        r_ohop    <= n_ohop;
        r_ofound  <= n_ofound;
        r_odrop   <= n_odrop;
        r_best    <= n_best;
        r_dx2     <= D_W'(ax * ax);
        r_dy2     <= D_W'(ay * ay);
        r_ok2     <= ent_ok;
        r_addr2   <= rd.addr;
        if (in_ch.valid && in_ch.ready) begin
            r_act  <= t_action'(in_ch.action);
            r_addr <= in_ch.node_addr;
            r_id   <= in_ch.node_id;
            r_road <= in_ch.road_id[RD_W-1:0];
            r_px   <= in_ch.pos_x[CO_W-1:0];
            r_py   <= in_ch.pos_y[CO_W-1:0];
            r_dir  <= in_ch.direction;
            r_now  <= in_ch.now_time;
        end
    end
endmodule
`default_nettype wire
